// ===== rtl/utccal_pkg.sv =====
// Shared types, constants and helpers for the UTC calendar to Unix seconds block.
// No dependencies; every rtl file imports this package.
package utccal_pkg;

	// Field limits and calendar constants
	localparam int unsigned SEC_LIMIT      = 61;
	localparam int unsigned MIN_LIMIT      = 60;
	localparam int unsigned HOUR_LIMIT     = 24;
	localparam int unsigned DAY_LIMIT      = 32;
	localparam int unsigned MONTH_LIMIT    = 12;
	localparam int unsigned MIN_YEAR_OFS   = 70;
	localparam int unsigned YEAR_BASE      = 1900;
	localparam int unsigned EPOCH_YEAR     = 1970;
	localparam int unsigned SECS_PER_MIN   = 60;
	localparam int unsigned SECS_PER_HOUR  = 3600;
	localparam int unsigned SECS_PER_DAY   = 86400;
	localparam int unsigned DAYS_PER_YEAR  = 365;
	// floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 43699
	localparam int unsigned DIV100_MUL     = 5243;
	localparam int unsigned DIV100_SHIFT   = 19;
	// leap years in 1 .. EPOCH_YEAR-1
	localparam int unsigned LEAPS_AT_EPOCH = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
		+ (EPOCH_YEAR - 1) / 400;

	// Error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_SECOND = 3'd1;
	localparam logic [2:0] ERR_MINUTE = 3'd2;
	localparam logic [2:0] ERR_HOUR   = 3'd3;
	localparam logic [2:0] ERR_DAY    = 3'd4;
	localparam logic [2:0] ERR_MONTH  = 3'd5;
	localparam logic [2:0] ERR_YEAR   = 3'd6;

	// Request and response payloads
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day_of_month;
		logic [3:0] month_index;
		logic [9:0] year_since_1900;
	} utc_req_t;

	typedef struct packed {
		logic [34:0] unix_seconds;
		logic [2:0]  error_code;
	} utc_rsp_t;

	// Stage 1 -> stage 2
	typedef struct packed {
		logic [2:0]  err;
		logic [9:0]  year_ofs;     // years since 1970
		logic [9:0]  prev_div4;    // (year-1) / 4
		logic [24:0] prev_prod;    // (year-1) * DIV100_MUL
		logic [11:0] year;
		logic [24:0] year_prod;    // year * DIV100_MUL
		logic        late_month;   // March or later
		logic [8:0]  doy_base;     // day of year ignoring leap day
		logic [16:0] sod;          // second of day
	} utccal_s1_t;

	// Stage 2 -> stage 3
	typedef struct packed {
		logic [2:0]  err;
		logic [18:0] days;
		logic [16:0] sod;
	} utccal_s2_t;

	// Days before the first of each month in a common year
	function automatic logic [8:0] cum_days(input logic [3:0] mon);
		logic [8:0] d;
		unique case (mon)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/utc_calendar_to_unix_seconds_top.sv =====
// UTC broken-down time to Unix seconds, three-stage pipeline.
// Depends on utccal_pkg, utccal_check, utccal_days, utccal_secs.
//
// Converts a UTC second/minute/hour/day/month/year-since-1900 request to
// seconds since 1970-01-01 (proleptic Gregorian). Fields are range checked
// in order second, minute, hour, day, month, year; the first bad one sets
// error_code and the timestamp reads zero. Day of month is not checked
// against the month length. The response is registered through three register
// stages (checks and reciprocal products, day count, seconds multiply), and the
// first stage loads at the accepting edge. One request is accepted per cycle
// while req_stall is low. A stage that holds no request always takes a new one,
// so stall only rises when every stage is full and the response is stalled.
module utc_calendar_to_unix_seconds_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  utccal_pkg::utc_req_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output utccal_pkg::utc_rsp_t  rsp
);
	import utccal_pkg::*;

	logic       valid_s1;
	logic       valid_s2;
	logic       stall_s2;
	logic       stall_s3;
	utccal_s1_t data_s1;
	utccal_s2_t data_s2;

	utccal_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req_valid),
		.in_data    (req),
		.stall      (req_stall),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.next_stall (stall_s2)
	);

	utccal_days u_days (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.stall      (stall_s2),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.next_stall (stall_s3)
	);

	utccal_secs u_secs (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.stall      (stall_s3),
		.valid_s3   (rsp_valid),
		.data_s3    (rsp),
		.next_stall (rsp_stall)
	);

	// An error response carries a zero timestamp
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error_code != ERR_NONE) |-> (rsp.unix_seconds == '0))
		else $error("error response with nonzero timestamp");

	// Error code stays within the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.error_code <= ERR_YEAR))
		else $error("undefined error code");

	// Request side only stalls when every stage is full and output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && rsp_valid && rsp_stall))
		else $error("request stalled with a free stage");

endmodule

// ===== rtl/utccal_check.sv =====
// Stage 1: field range checks, second of day, month offset, and the
// divide-by-100 reciprocal products. Depends on utccal_pkg.
module utccal_check (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  utccal_pkg::utc_req_t    in_data,
	output logic                    stall,
	output logic                    valid_s1,
	output utccal_pkg::utccal_s1_t  data_s1,
	input  logic                    next_stall
);
	import utccal_pkg::*;

	logic [2:0]  err;
	logic [11:0] year;
	logic [11:0] prev;
	utccal_s1_t  nxt;

	// First failing field wins
	always_comb begin
		priority if (in_data.second >= 6'(SEC_LIMIT)) begin
			err = ERR_SECOND;
		end else if (in_data.minute >= 6'(MIN_LIMIT)) begin
			err = ERR_MINUTE;
		end else if (in_data.hour >= 5'(HOUR_LIMIT)) begin
			err = ERR_HOUR;
		end else if (in_data.day_of_month == 5'd0) begin
			err = ERR_DAY;
		end else if (in_data.month_index >= 4'(MONTH_LIMIT)) begin
			err = ERR_MONTH;
		end else if (in_data.year_since_1900 < 10'(MIN_YEAR_OFS)) begin
			err = ERR_YEAR;
		end else begin
			err = ERR_NONE;
		end
	end

	// Year arithmetic and time of day
	always_comb begin
		year = 12'(YEAR_BASE) + {2'b00, in_data.year_since_1900};
		prev = year - 12'd1;
		nxt.err        = err;
		nxt.year_ofs   = in_data.year_since_1900 - 10'(MIN_YEAR_OFS);
		nxt.prev_div4  = prev[11:2];
		nxt.prev_prod  = {13'd0, prev} * 25'(DIV100_MUL);
		nxt.year       = year;
		nxt.year_prod  = {13'd0, year} * 25'(DIV100_MUL);
		nxt.late_month = (in_data.month_index >= 4'd2);
		nxt.doy_base   = cum_days(in_data.month_index) + {4'd0, in_data.day_of_month} - 9'd1;
		nxt.sod        = 17'(in_data.hour) * 17'(SECS_PER_HOUR)
			+ 17'(in_data.minute) * 17'(SECS_PER_MIN) + 17'(in_data.second);
	end

	assign stall = valid_s1 && next_stall;

	// Stage register; a bubble lets a request in even when downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !stall) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/utccal_days.sv =====
// Stage 2: leap-year count since the epoch, leap test, and days since epoch.
// Depends on utccal_pkg.
module utccal_days (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	input  utccal_pkg::utccal_s1_t  data_s1,
	output logic                    stall,
	output logic                    valid_s2,
	output utccal_pkg::utccal_s2_t  data_s2,
	input  logic                    next_stall
);
	import utccal_pkg::*;

	logic [5:0]  prev_div100;
	logic [5:0]  year_div100;
	logic [11:0] century;
	logic [10:0] leaps;
	logic        is_leap;
	utccal_s2_t  nxt;

	// Leap count and day total
	always_comb begin
		prev_div100 = data_s1.prev_prod[DIV100_SHIFT +: 6];
		year_div100 = data_s1.year_prod[DIV100_SHIFT +: 6];
		century     = 12'(year_div100) * 12'd100;
		leaps       = 11'(data_s1.prev_div4) - 11'(prev_div100) + 11'(prev_div100[5:2])
			- 11'(LEAPS_AT_EPOCH);
		is_leap     = (data_s1.year[1:0] == 2'b00)
			&& ((data_s1.year != century) || (year_div100[1:0] == 2'b00));
		nxt.err  = data_s1.err;
		nxt.sod  = data_s1.sod;
		nxt.days = 19'(data_s1.year_ofs) * 19'(DAYS_PER_YEAR) + 19'(leaps)
			+ 19'(data_s1.doy_base) + 19'(data_s1.late_month && is_leap);
	end

	assign stall = valid_s2 && next_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !stall) begin
			data_s2 <= nxt;
		end
	end

endmodule

// ===== rtl/utccal_secs.sv =====
// Stage 3: days times seconds per day plus second of day, zeroed on error.
// Holds the response register. Depends on utccal_pkg.
module utccal_secs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s2,
	input  utccal_pkg::utccal_s2_t  data_s2,
	output logic                    stall,
	output logic                    valid_s3,
	output utccal_pkg::utc_rsp_t    data_s3,
	input  logic                    next_stall
);
	import utccal_pkg::*;

	utc_rsp_t nxt;

	always_comb begin
		nxt.error_code = data_s2.err;
		if (data_s2.err == ERR_NONE) begin
			nxt.unix_seconds = 35'(data_s2.days) * 35'(SECS_PER_DAY) + 35'(data_s2.sod);
		end else begin
			nxt.unix_seconds = '0;
		end
	end

	assign stall = valid_s3 && next_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!stall) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !stall) begin
			data_s3 <= nxt;
		end
	end

endmodule
